FILE: rtl/hh_pkg.sv
// Package of shared constants, register codes and pipeline types for the heading hold loop.
package hh_pkg;

   // Fixed point format of angles and rates
   localparam int FRAC_BITS = 12;
   // Longest control period still treated as valid, in microseconds
   localparam int MAX_PERIOD_US = 50000;

   // pi in Q30, rounded to nearest at FRAC_BITS fraction bits
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam int PI_Q = int'((PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
   localparam int TWO_PI_Q = 2 * PI_Q;

   // Field widths
   localparam int CMD_W    = 16;
   localparam int HEAD_W   = 15;
   localparam int GAIN_W   = 16;
   localparam int THRESH_W = 15;
   localparam int PERIOD_W = 16;

   // Configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Cycles from the accepting edge to the edge that takes the result
   localparam int HH_LATENCY = 6;

   // Register map, word index
   typedef enum logic [2:0] {
      REG_HOLD_ENABLE    = 3'd0,
      REG_PROP_GAIN      = 3'd1,
      REG_DAMP_GAIN      = 3'd2,
      REG_SPEED_DEADBAND = 3'd3,
      REG_TURN_DEADBAND  = 3'd4,
      REG_TURN_LIMIT     = 3'd5,
      REG_TARGET_HEADING = 3'd6,
      REG_TARGET_LOCKED  = 3'd7
   } hh_reg_type;

   // Configuration register set
   typedef struct packed {
      logic                       hold_enable;
      logic [GAIN_W-1:0]          prop_gain;
      logic [GAIN_W-1:0]          damp_gain;
      logic [THRESH_W-1:0]        speed_deadband;
      logic [THRESH_W-1:0]        turn_deadband;
      logic [THRESH_W-1:0]        turn_limit;
      logic signed [HEAD_W-1:0]   target_heading;
      logic                       target_locked;
   } hh_cfg_type;

   // One input sample
   typedef struct packed {
      logic signed [CMD_W-1:0]    speed_x;
      logic signed [CMD_W-1:0]    speed_y;
      logic signed [CMD_W-1:0]    turn_request;
      logic signed [HEAD_W-1:0]   heading;
      logic signed [CMD_W-1:0]    gyro_rate;
      logic [PERIOD_W-1:0]        period_us;
      logic                       sample_ok;
   } hh_sample_type;

   // After the gate stage: bypass decision and wrapped error
   typedef struct packed {
      logic                       valid;
      logic                       bypass;
      logic signed [CMD_W-1:0]    turn;
      logic signed [HEAD_W-1:0]   err;
      logic signed [CMD_W-1:0]    rate;
   } hh_gate_type;

   // After the feedback stages: clamped correction
   typedef struct packed {
      logic                       valid;
      logic                       bypass;
      logic signed [CMD_W-1:0]    turn;
      logic signed [HEAD_W-1:0]   err;
      logic signed [CMD_W-1:0]    corr;
   } hh_fb_type;

endpackage

FILE: rtl/hh_regs.sv
// Configuration register bank with its APB-style access port.
module hh_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [hh_pkg::ADDR_W-1:0]   paddr,
   input  logic [hh_pkg::DATA_W-1:0]   pwdata,
   output logic [hh_pkg::DATA_W-1:0]   prdata,
   output logic                        pready,
   output hh_pkg::hh_cfg_type          cfg
);
   import hh_pkg::*;

   hh_cfg_type cfg_ff;
   hh_cfg_type cfg_in;
   hh_reg_type reg_sel;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_sel = hh_reg_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite & pready;
   assign cfg     = cfg_ff;

   // Next register values on a write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_HOLD_ENABLE:    cfg_in.hold_enable    = pwdata[0];
            REG_PROP_GAIN:      cfg_in.prop_gain      = pwdata[GAIN_W-1:0];
            REG_DAMP_GAIN:      cfg_in.damp_gain      = pwdata[GAIN_W-1:0];
            REG_SPEED_DEADBAND: cfg_in.speed_deadband = pwdata[THRESH_W-1:0];
            REG_TURN_DEADBAND:  cfg_in.turn_deadband  = pwdata[THRESH_W-1:0];
            REG_TURN_LIMIT:     cfg_in.turn_limit     = pwdata[THRESH_W-1:0];
            REG_TARGET_HEADING: cfg_in.target_heading = $signed(pwdata[HEAD_W-1:0]);
            REG_TARGET_LOCKED:  cfg_in.target_locked  = pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_enable    <= 1'b1;
         cfg_ff.prop_gain      <= GAIN_W'(12288);
         cfg_ff.damp_gain      <= GAIN_W'(512);
         cfg_ff.speed_deadband <= THRESH_W'(41);
         cfg_ff.turn_deadband  <= THRESH_W'(328);
         cfg_ff.turn_limit     <= THRESH_W'(4096);
         cfg_ff.target_heading <= '0;
         cfg_ff.target_locked  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux, zero extended
   always_comb begin
      case (reg_sel)
         REG_HOLD_ENABLE:    prdata = DATA_W'(cfg_ff.hold_enable);
         REG_PROP_GAIN:      prdata = DATA_W'(cfg_ff.prop_gain);
         REG_DAMP_GAIN:      prdata = DATA_W'(cfg_ff.damp_gain);
         REG_SPEED_DEADBAND: prdata = DATA_W'(cfg_ff.speed_deadband);
         REG_TURN_DEADBAND:  prdata = DATA_W'(cfg_ff.turn_deadband);
         REG_TURN_LIMIT:     prdata = DATA_W'(cfg_ff.turn_limit);
         REG_TARGET_HEADING: prdata = DATA_W'($unsigned(cfg_ff.target_heading));
         REG_TARGET_LOCKED:  prdata = DATA_W'(cfg_ff.target_locked);
         default:            prdata = '0;
      endcase
   end

endmodule

FILE: rtl/hh_gate.sv
// Gate stage: bypass decision and wrapped heading error, registered.
module hh_gate (
   input  logic                   clock,
   input  logic                   reset,
   input  hh_pkg::hh_cfg_type     cfg,
   input  logic                   smp_valid,
   input  hh_pkg::hh_sample_type  smp,
   output hh_pkg::hh_gate_type    gate
);
   import hh_pkg::*;

   // Working width for the angle difference and its wrap
   localparam int DIFF_W = HEAD_W + 3;
   localparam logic signed [DIFF_W-1:0] PI_W     = DIFF_W'(PI_Q);
   localparam logic signed [DIFF_W-1:0] TWO_PI_W = DIFF_W'(TWO_PI_Q);

   hh_gate_type gate_ff;
   hh_gate_type gate_in;

   logic signed [CMD_W:0]  mag_x;
   logic signed [CMD_W:0]  mag_y;
   logic signed [CMD_W:0]  mag_turn;
   logic                   moving;
   logic                   period_ok;
   logic                   bypass;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] rem;
   logic signed [DIFF_W-1:0] wrapped;

   // Magnitudes of the commands, one bit wider so the most negative value fits
   always_comb begin
      mag_x    = smp.speed_x[CMD_W-1] ? -(CMD_W+1)'(smp.speed_x) : (CMD_W+1)'(smp.speed_x);
      mag_y    = smp.speed_y[CMD_W-1] ? -(CMD_W+1)'(smp.speed_y) : (CMD_W+1)'(smp.speed_y);
      mag_turn = smp.turn_request[CMD_W-1] ? -(CMD_W+1)'(smp.turn_request)
                                           : (CMD_W+1)'(smp.turn_request);
   end

   // Bypass when disabled, invalid, out of period, rotating, standing or unlocked
   always_comb begin
      period_ok = (smp.period_us != '0) && (smp.period_us <= PERIOD_W'(MAX_PERIOD_US));
      moving    = ($unsigned(mag_x) > (CMD_W+1)'(cfg.speed_deadband)) ||
                  ($unsigned(mag_y) > (CMD_W+1)'(cfg.speed_deadband));
      bypass    = !cfg.hold_enable || !smp.sample_ok || !period_ok ||
                  ($unsigned(mag_turn) > (CMD_W+1)'(cfg.turn_deadband)) ||
                  !moving || !cfg.target_locked;
   end

   // Heading error: truncating remainder by two pi, then into [-pi, pi)
   always_comb begin
      diff = DIFF_W'(cfg.target_heading) - DIFF_W'(smp.heading);
      if (diff >= TWO_PI_W) begin
         rem = diff - TWO_PI_W;
      end else if (diff <= -TWO_PI_W) begin
         rem = diff + TWO_PI_W;
      end else begin
         rem = diff;
      end
      if (rem >= PI_W) begin
         wrapped = rem - TWO_PI_W;
      end else if (rem < -PI_W) begin
         wrapped = rem + TWO_PI_W;
      end else begin
         wrapped = rem;
      end
   end

   always_comb begin
      gate_in.valid  = smp_valid;
      gate_in.bypass = bypass;
      gate_in.turn   = smp.turn_request;
      gate_in.err    = wrapped[HEAD_W-1:0];
      gate_in.rate   = smp.gyro_rate;
   end

   // Stage register; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff.valid <= 1'b0;
      end else begin
         gate_ff.valid <= gate_in.valid;
      end
      gate_ff.bypass <= gate_in.bypass;
      gate_ff.turn   <= gate_in.turn;
      gate_ff.err    <= gate_in.err;
      gate_ff.rate   <= gate_in.rate;
   end

   assign gate = gate_ff;

endmodule

FILE: rtl/hh_feedback.sv
// Feedback stages: gain products, rounding, P clamp, PD sum and final clamp.
module hh_feedback (
   input  logic                 clock,
   input  logic                 reset,
   input  hh_pkg::hh_cfg_type   cfg,
   input  hh_pkg::hh_gate_type  gate,
   output hh_pkg::hh_fb_type    fb
);
   import hh_pkg::*;

   localparam int PPROD_W = GAIN_W + HEAD_W + 1;
   localparam int DPROD_W = GAIN_W + CMD_W + 1;
   localparam int PRND_W  = PPROD_W - 8 + 1;
   localparam int DRND_W  = DPROD_W - 8 + 1;
   localparam int SUM_W   = DRND_W + 2;

   // Stage 1: products
   logic                        s1_valid_ff;
   logic                        s1_bypass_ff;
   logic signed [CMD_W-1:0]     s1_turn_ff;
   logic signed [HEAD_W-1:0]    s1_err_ff;
   logic signed [PPROD_W-1:0]   s1_pprod_ff;
   logic signed [DPROD_W-1:0]   s1_dprod_ff;
   logic signed [PPROD_W-1:0]   s1_pprod_in;
   logic signed [DPROD_W-1:0]   s1_dprod_in;

   // Stage 2: rounded and clamped P, negated rounded D
   logic                        s2_valid_ff;
   logic                        s2_bypass_ff;
   logic signed [CMD_W-1:0]     s2_turn_ff;
   logic signed [HEAD_W-1:0]    s2_err_ff;
   logic signed [CMD_W-1:0]     s2_p_ff;
   logic signed [DRND_W:0]      s2_d_ff;
   logic signed [CMD_W-1:0]     s2_p_in;
   logic signed [DRND_W:0]      s2_d_in;
   logic signed [PPROD_W:0]     p_biased;
   logic signed [DPROD_W:0]     d_biased;
   logic signed [PRND_W-1:0]    p_round;
   logic signed [DRND_W-1:0]    d_round;
   logic signed [PRND_W-1:0]    p_lim;

   // Stage 3: clamped sum
   hh_fb_type                   fb_ff;
   hh_fb_type                   fb_in;
   logic signed [SUM_W-1:0]     pd_sum;
   logic signed [SUM_W-1:0]     sum_lim;

   // Gains are unsigned, widened by a zero sign bit
   always_comb begin
      s1_pprod_in = $signed({1'b0, cfg.prop_gain}) * gate.err;
      s1_dprod_in = $signed({1'b0, cfg.damp_gain}) * gate.rate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= gate.valid;
      end
      s1_bypass_ff <= gate.bypass;
      s1_turn_ff   <= gate.turn;
      s1_err_ff    <= gate.err;
      s1_pprod_ff  <= s1_pprod_in;
      s1_dprod_ff  <= s1_dprod_in;
   end

   // Round half up by eight bits, clamp P to the limit, negate D
   always_comb begin
      p_biased = (PPROD_W+1)'(s1_pprod_ff) + (PPROD_W+1)'(128);
      d_biased = (DPROD_W+1)'(s1_dprod_ff) + (DPROD_W+1)'(128);
      p_round  = PRND_W'(p_biased >>> 8);
      d_round  = DRND_W'(d_biased >>> 8);
      p_lim    = PRND_W'(cfg.turn_limit);
      if (p_round > p_lim) begin
         s2_p_in = CMD_W'(p_lim);
      end else if (p_round < -p_lim) begin
         s2_p_in = CMD_W'(-p_lim);
      end else begin
         s2_p_in = CMD_W'(p_round);
      end
      s2_d_in = -(DRND_W+1)'(d_round);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_bypass_ff <= s1_bypass_ff;
      s2_turn_ff   <= s1_turn_ff;
      s2_err_ff    <= s1_err_ff;
      s2_p_ff      <= s2_p_in;
      s2_d_ff      <= s2_d_in;
   end

   // PD sum clamped to the limit; zero on bypass
   always_comb begin
      pd_sum       = SUM_W'(s2_p_ff) + SUM_W'(s2_d_ff);
      sum_lim      = SUM_W'(cfg.turn_limit);
      fb_in.valid  = s2_valid_ff;
      fb_in.bypass = s2_bypass_ff;
      fb_in.turn   = s2_turn_ff;
      fb_in.err    = s2_bypass_ff ? '0 : s2_err_ff;
      if (s2_bypass_ff) begin
         fb_in.corr = '0;
      end else if (pd_sum > sum_lim) begin
         fb_in.corr = CMD_W'(sum_lim);
      end else if (pd_sum < -sum_lim) begin
         fb_in.corr = CMD_W'(-sum_lim);
      end else begin
         fb_in.corr = CMD_W'(pd_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff.valid <= 1'b0;
      end else begin
         fb_ff.valid <= fb_in.valid;
      end
      fb_ff.bypass <= fb_in.bypass;
      fb_ff.turn   <= fb_in.turn;
      fb_ff.err    <= fb_in.err;
      fb_ff.corr   <= fb_in.corr;
   end

   assign fb = fb_ff;

endmodule

FILE: rtl/heading_hold_pd_loop.sv
// Top level of the heading hold PD loop: input register, pipeline and result register.
//
//  Channel  | Ports                                   | Transfer
//  ---------+-----------------------------------------+----------------------------------
//  request  | start, busy, req_*                      | edge with start high, busy low
//  result   | rsp_strobe, rsp_*                       | edge ending the one strobe cycle
//  config   | psel, penable, pwrite, paddr, pwdata,   | edge with psel, penable, pwrite,
//           | prdata, pready                          | pready high
//
// A new sample is taken every cycle; busy is high only during reset.
// Results leave in the order of their samples, one strobe cycle each, after passing
// through the six register stages: input, gate, products, rounding, PD clamp and
// output saturation.
// Synchronous reset clears the valid bits and loads the register reset values.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module heading_hold_pd_loop (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_speed_x,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_speed_y,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_turn_request,
   input  logic signed [hh_pkg::HEAD_W-1:0]    req_heading,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_gyro_rate,
   input  logic [hh_pkg::PERIOD_W-1:0]         req_period_us,
   input  logic                                req_sample_ok,
   // result
   output logic                                rsp_strobe,
   output logic signed [hh_pkg::CMD_W-1:0]     rsp_turn_out,
   output logic signed [hh_pkg::CMD_W-1:0]     rsp_correction,
   output logic signed [hh_pkg::HEAD_W-1:0]    rsp_heading_error,
   output logic                                rsp_correcting,
   // configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hh_pkg::ADDR_W-1:0]           paddr,
   input  logic [hh_pkg::DATA_W-1:0]           pwdata,
   output logic [hh_pkg::DATA_W-1:0]           prdata,
   output logic                                pready
);
   import hh_pkg::*;

   hh_cfg_type     cfg;
   hh_sample_type  smp_ff;
   hh_sample_type  smp_in;
   logic           smp_valid_ff;
   logic           smp_valid_in;
   hh_gate_type    gate;
   hh_fb_type      fb;

   logic signed [CMD_W:0]    total;
   logic                     out_valid_ff;
   logic signed [CMD_W-1:0]  out_turn_ff;
   logic signed [CMD_W-1:0]  out_turn_in;
   logic signed [CMD_W-1:0]  out_corr_ff;
   logic signed [HEAD_W-1:0] out_err_ff;
   logic                     out_correcting_ff;

   localparam logic signed [CMD_W:0] OUT_MAX = (CMD_W+1)'((2 ** (CMD_W-1)) - 1);
   localparam logic signed [CMD_W:0] OUT_MIN = -(CMD_W+1)'(2 ** (CMD_W-1));

   assign busy = reset;

   hh_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input register
   always_comb begin
      smp_valid_in        = start & ~busy;
      smp_in.speed_x      = req_speed_x;
      smp_in.speed_y      = req_speed_y;
      smp_in.turn_request = req_turn_request;
      smp_in.heading      = req_heading;
      smp_in.gyro_rate    = req_gyro_rate;
      smp_in.period_us    = req_period_us;
      smp_in.sample_ok    = req_sample_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
      end else begin
         smp_valid_ff <= smp_valid_in;
      end
      smp_ff <= smp_in;
   end

   hh_gate u_gate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .smp_valid (smp_valid_ff),
      .smp       (smp_ff),
      .gate      (gate)
   );

   hh_feedback u_feedback (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .gate  (gate),
      .fb    (fb)
   );

   // Final add with 16-bit saturation
   always_comb begin
      total = (CMD_W+1)'(fb.turn) + (CMD_W+1)'(fb.corr);
      if (total > OUT_MAX) begin
         out_turn_in = CMD_W'(OUT_MAX);
      end else if (total < OUT_MIN) begin
         out_turn_in = CMD_W'(OUT_MIN);
      end else begin
         out_turn_in = CMD_W'(total);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= fb.valid;
      end
      out_turn_ff       <= out_turn_in;
      out_corr_ff       <= fb.corr;
      out_err_ff        <= fb.err;
      out_correcting_ff <= ~fb.bypass;
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_turn_out      = out_turn_ff;
   assign rsp_correction    = out_corr_ff;
   assign rsp_heading_error = out_err_ff;
   assign rsp_correcting    = out_correcting_ff;

endmodule

FILE: rtl/hh_checker.sv
// Port-level checker for the heading hold loop, bound to the top level.
module hh_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_speed_x,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_speed_y,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_turn_request,
   input  logic signed [hh_pkg::HEAD_W-1:0]    req_heading,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_gyro_rate,
   input  logic [hh_pkg::PERIOD_W-1:0]         req_period_us,
   input  logic                                req_sample_ok,
   input  logic                                rsp_strobe,
   input  logic signed [hh_pkg::CMD_W-1:0]     rsp_turn_out,
   input  logic signed [hh_pkg::CMD_W-1:0]     rsp_correction,
   input  logic signed [hh_pkg::HEAD_W-1:0]    rsp_heading_error,
   input  logic                                rsp_correcting,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hh_pkg::ADDR_W-1:0]           paddr,
   input  logic [hh_pkg::DATA_W-1:0]           pwdata,
   input  logic [hh_pkg::DATA_W-1:0]           prdata,
   input  logic                                pready
);
   import hh_pkg::*;

   // Every accepted sample yields a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##HH_LATENCY rsp_strobe)
      else $error("accepted sample gave no result");

   // No result without a sample accepted at the matching edge
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, HH_LATENCY))
      else $error("result without an accepted sample");

   // A bypassed sample passes the rotation command through with zero terms
   a_bypass_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_correcting) |->
         (rsp_correction == '0 && rsp_heading_error == '0 &&
          rsp_turn_out == $past(req_turn_request, HH_LATENCY)))
      else $error("bypass result differs from the rotation command");

   // Correction only for a valid sample with a nonzero period
   a_correct_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_correcting) |->
         $past(req_sample_ok && req_period_us != '0, HH_LATENCY))
      else $error("correction applied to an invalid sample");

endmodule

bind heading_hold_pd_loop hh_checker u_hh_checker (.*);

FILE: tb/heading_hold_checker.sv
// Result checker for the heading hold loop: tracks the settings, predicts each result and compares.
module heading_hold_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_speed_x,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_speed_y,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_turn_request,
   input  logic signed [hh_pkg::HEAD_W-1:0]    req_heading,
   input  logic signed [hh_pkg::CMD_W-1:0]     req_gyro_rate,
   input  logic [hh_pkg::PERIOD_W-1:0]         req_period_us,
   input  logic                                req_sample_ok,
   input  logic                                rsp_strobe,
   input  logic signed [hh_pkg::CMD_W-1:0]     rsp_turn_out,
   input  logic signed [hh_pkg::CMD_W-1:0]     rsp_correction,
   input  logic signed [hh_pkg::HEAD_W-1:0]    rsp_heading_error,
   input  logic                                rsp_correcting,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [hh_pkg::ADDR_W-1:0]           paddr,
   input  logic [hh_pkg::DATA_W-1:0]           pwdata,
   output int                                  failures,
   output int                                  pending
);
   import hh_pkg::*;

   typedef struct packed {
      logic signed [CMD_W-1:0]    turn_out;
      logic signed [CMD_W-1:0]    correction;
      logic signed [HEAD_W-1:0]   heading_error;
      logic                       correcting;
   } turn_result_type;

   localparam hh_cfg_type SETTINGS_AT_RESET = '{
      hold_enable: 1'b1, prop_gain: 16'd12288, damp_gain: 16'd512,
      speed_deadband: 15'd41, turn_deadband: 15'd328, turn_limit: 15'd4096,
      target_heading: 15'sd0, target_locked: 1'b0};

   hh_cfg_type      settings;
   turn_result_type turn_results_q [$];

   // Q8.8 gain product back to Q12, halves rounded upwards
   function automatic longint round_q8(longint v);
      return (v + 128) >>> 8;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic turn_result_type predict_turn_command(hh_sample_type s, hh_cfg_type c);
      int              turn_mag;
      int              sx_mag;
      int              sy_mag;
      int              err;
      bit              hold;
      longint          lim;
      longint          p_term;
      longint          d_term;
      longint          corr;
      longint          total;
      turn_result_type r;
      turn_mag = (s.turn_request < 0) ? -int'(s.turn_request) : int'(s.turn_request);
      sx_mag   = (s.speed_x < 0) ? -int'(s.speed_x) : int'(s.speed_x);
      sy_mag   = (s.speed_y < 0) ? -int'(s.speed_y) : int'(s.speed_y);
      // correction only while enabled, moving, not turning, with a valid sample and a locked target
      hold = c.hold_enable && s.sample_ok && (s.period_us != 0) &&
             (int'(s.period_us) <= MAX_PERIOD_US) &&
             (turn_mag <= int'(c.turn_deadband)) &&
             ((sx_mag > int'(c.speed_deadband)) || (sy_mag > int'(c.speed_deadband))) &&
             c.target_locked;
      err  = 0;
      corr = 0;
      if (hold) begin
         // error folded into [-pi, pi)
         err = (int'(c.target_heading) - int'(s.heading)) % TWO_PI_Q;
         if (err >= PI_Q) begin
            err -= TWO_PI_Q;
         end else if (err < -PI_Q) begin
            err += TWO_PI_Q;
         end
         lim    = longint'(c.turn_limit);
         p_term = clip(round_q8(longint'(c.prop_gain) * err), -lim, lim);
         d_term = -round_q8(longint'(c.damp_gain) * longint'(s.gyro_rate));
         corr   = clip(p_term + d_term, -lim, lim);
      end
      total = clip(longint'(s.turn_request) + corr, -32768, 32767);
      r.turn_out      = total[CMD_W-1:0];
      r.correction    = corr[CMD_W-1:0];
      r.heading_error = err[HEAD_W-1:0];
      r.correcting    = hold;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR: %0t %s: got %0d, expected %0d", $realtime, what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      turn_result_type got;
      turn_result_type want;
      hh_sample_type   s;
      if (reset) begin
         settings = SETTINGS_AT_RESET;
         turn_results_q.delete();
         pending = 0;
      end else begin
         // result transfer: compare against the oldest prediction
         if (rsp_strobe) begin
            got = '{rsp_turn_out, rsp_correction, rsp_heading_error, rsp_correcting};
            if (turn_results_q.size() == 0) begin
               report_mismatch("result with nothing outstanding, turn_out",
                               int'(got.turn_out), 0);
            end else begin
               want = turn_results_q.pop_front();
               if (got.turn_out !== want.turn_out)
                  report_mismatch("turn_out", int'(got.turn_out), int'(want.turn_out));
               if (got.correction !== want.correction)
                  report_mismatch("correction", int'(got.correction), int'(want.correction));
               if (got.heading_error !== want.heading_error)
                  report_mismatch("heading_error", int'(got.heading_error),
                                  int'(want.heading_error));
               if (got.correcting !== want.correcting)
                  report_mismatch("correcting", int'(got.correcting), int'(want.correcting));
            end
         end
         // sample transfer: predict with the settings in force
         if (start && !busy) begin
            s = '{req_speed_x, req_speed_y, req_turn_request, req_heading,
                  req_gyro_rate, req_period_us, req_sample_ok};
            turn_results_q.push_back(predict_turn_command(s, settings));
         end
         // register write transfer
         if (psel && penable && pwrite && pready) begin
            case (hh_reg_type'(paddr[4:2]))
               REG_HOLD_ENABLE:    settings.hold_enable    = pwdata[0];
               REG_PROP_GAIN:      settings.prop_gain      = pwdata[GAIN_W-1:0];
               REG_DAMP_GAIN:      settings.damp_gain      = pwdata[GAIN_W-1:0];
               REG_SPEED_DEADBAND: settings.speed_deadband = pwdata[THRESH_W-1:0];
               REG_TURN_DEADBAND:  settings.turn_deadband  = pwdata[THRESH_W-1:0];
               REG_TURN_LIMIT:     settings.turn_limit     = pwdata[THRESH_W-1:0];
               REG_TARGET_HEADING: settings.target_heading = pwdata[HEAD_W-1:0];
               REG_TARGET_LOCKED:  settings.target_locked  = pwdata[0];
               default: ;
            endcase
         end
         pending = turn_results_q.size();
      end
   end

endmodule

FILE: tb/testbench.sv
// Testbench top for the heading hold loop: clock, reset, register set-up, sample stimulus and verdict.
module testbench;
   import hh_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 153;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic signed [CMD_W-1:0]    req_speed_x;
   logic signed [CMD_W-1:0]    req_speed_y;
   logic signed [CMD_W-1:0]    req_turn_request;
   logic signed [HEAD_W-1:0]   req_heading;
   logic signed [CMD_W-1:0]    req_gyro_rate;
   logic [PERIOD_W-1:0]        req_period_us;
   logic                       req_sample_ok;
   logic                       rsp_strobe;
   logic signed [CMD_W-1:0]    rsp_turn_out;
   logic signed [CMD_W-1:0]    rsp_correction;
   logic signed [HEAD_W-1:0]   rsp_heading_error;
   logic                       rsp_correcting;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [ADDR_W-1:0]          paddr;
   logic [DATA_W-1:0]          pwdata;
   logic [DATA_W-1:0]          prdata;
   logic                       pready;
   int                         failures;
   int                         pending;
   int                         cycle_count;
   int                         gap_pct [4] = '{0, 54, 0, 12};
   hh_cfg_type                 active_cfg;

   heading_hold_pd_loop DUT (
      .clock, .reset, .start, .busy,
      .req_speed_x, .req_speed_y, .req_turn_request, .req_heading,
      .req_gyro_rate, .req_period_us, .req_sample_ok,
      .rsp_strobe, .rsp_turn_out, .rsp_correction, .rsp_heading_error, .rsp_correcting,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   heading_hold_checker hh_check (
      .clock, .reset, .start, .busy,
      .req_speed_x, .req_speed_y, .req_turn_request, .req_heading,
      .req_gyro_rate, .req_period_us, .req_sample_ok,
      .rsp_strobe, .rsp_turn_out, .rsp_correction, .rsp_heading_error, .rsp_correcting,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .failures, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // setup and access cycle; psel and penable are left high for a following write
   task automatic csr_write(hh_reg_type r, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic write_settings(hh_cfg_type c);
      csr_write(REG_HOLD_ENABLE,    DATA_W'(c.hold_enable));
      csr_write(REG_PROP_GAIN,      DATA_W'(c.prop_gain));
      csr_write(REG_DAMP_GAIN,      DATA_W'(c.damp_gain));
      csr_write(REG_SPEED_DEADBAND, DATA_W'(c.speed_deadband));
      csr_write(REG_TURN_DEADBAND,  DATA_W'(c.turn_deadband));
      csr_write(REG_TURN_LIMIT,     DATA_W'(c.turn_limit));
      csr_write(REG_TARGET_HEADING, DATA_W'(c.target_heading));
      csr_write(REG_TARGET_LOCKED,  DATA_W'(c.target_locked));
      csr_release();
      active_cfg = c;
   endtask

   // random idle cycles, then hold start until the transfer
   task automatic send_sample(hh_sample_type s, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_speed_x      <= s.speed_x;
      req_speed_y      <= s.speed_y;
      req_turn_request <= s.turn_request;
      req_heading      <= s.heading;
      req_gyro_rate    <= s.gyro_rate;
      req_period_us    <= s.period_us;
      req_sample_ok    <= s.sample_ok;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // a sample that gets the correction under the reset gains
   function automatic hh_sample_type nominal_sample();
      return '{speed_x: 16'sd4096, speed_y: 16'sd0, turn_request: 16'sd0,
               heading: 15'sd1000, gyro_rate: 16'sd100, period_us: 16'd1000,
               sample_ok: 1'b1};
   endfunction

   function automatic logic signed [CMD_W-1:0] signed_of_mag(int mag);
      return $urandom_range(1) ? CMD_W'(-mag) : CMD_W'(mag);
   endfunction

   // mostly samples that pass the gate, the rest raw noise
   function automatic hh_sample_type random_sample(hh_cfg_type c);
      hh_sample_type s;
      int            mag;
      s = '{CMD_W'($urandom), CMD_W'($urandom), CMD_W'($urandom), HEAD_W'($urandom),
            CMD_W'($urandom), PERIOD_W'($urandom), 1'($urandom)};
      if ($urandom_range(99) < 75) begin
         mag = $urandom_range(32768, int'(c.speed_deadband) + 1);
         if ($urandom_range(1)) begin
            s.speed_x = signed_of_mag(mag);
         end else begin
            s.speed_y = signed_of_mag(mag);
         end
         s.turn_request = signed_of_mag($urandom_range(int'(c.turn_deadband)));
         s.period_us    = PERIOD_W'($urandom_range(MAX_PERIOD_US, 1));
         s.sample_ok    = 1'b1;
         if ($urandom_range(9) != 0) begin
            s.heading = HEAD_W'(int'($urandom_range(2 * PI_Q - 1)) - PI_Q);
         end
         if ($urandom_range(3) != 0) begin
            s.gyro_rate = CMD_W'(int'($urandom_range(4000)) - 2000);
         end
      end
      return s;
   endfunction

   // register settings for each phase, directed cases first, random ones after
   function automatic hh_cfg_type phase_settings(int ph);
      hh_cfg_type c;
      c = '{hold_enable: 1'b1, prop_gain: 16'd12288, damp_gain: 16'd512,
            speed_deadband: 15'd41, turn_deadband: 15'd328, turn_limit: 15'd4096,
            target_heading: 15'sd0, target_locked: 1'b1};
      case (ph)
         0: c.target_heading = HEAD_W'(int'($urandom_range(2 * PI_Q - 1)) - PI_Q);
         1: c.hold_enable = 1'b0;
         2: c.turn_limit = '0;
         3: begin
            c.prop_gain      = '1;
            c.damp_gain      = '1;
            c.speed_deadband = '0;
            c.turn_deadband  = '1;
            c.turn_limit     = '1;
            c.target_heading = 15'sh3fff;
         end
         4: begin
            c.prop_gain      = '0;
            c.damp_gain      = '0;
            c.speed_deadband = '1;
            c.turn_deadband  = '0;
            c.turn_limit     = 15'd1;
            c.target_heading = 15'sh4000;
         end
         default: begin
            c.hold_enable    = ($urandom_range(7) != 0);
            c.prop_gain      = GAIN_W'($urandom);
            c.damp_gain      = GAIN_W'($urandom);
            c.speed_deadband = THRESH_W'($urandom_range(4096));
            c.turn_deadband  = THRESH_W'($urandom);
            c.turn_limit     = THRESH_W'($urandom);
            c.target_heading = HEAD_W'($urandom);
            c.target_locked  = ($urandom_range(7) != 0);
         end
      endcase
      return c;
   endfunction

   initial begin
      hh_sample_type s;
      cycle_count      = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_speed_x      = '0;
      req_speed_y      = '0;
      req_turn_request = '0;
      req_heading      = '0;
      req_gyro_rate    = '0;
      req_period_us    = '0;
      req_sample_ok    = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed samples at reset gains with the target locked at zero
      csr_write(REG_TARGET_LOCKED, DATA_W'(1));
      csr_release();
      s = nominal_sample();                       send_sample(s, 0);
      s = nominal_sample(); s.sample_ok = 1'b0;   send_sample(s, 0);
      s = nominal_sample(); s.period_us = '0;     send_sample(s, 0);
      s = nominal_sample(); s.period_us = PERIOD_W'(MAX_PERIOD_US);     send_sample(s, 0);
      s = nominal_sample(); s.period_us = PERIOD_W'(MAX_PERIOD_US + 1); send_sample(s, 0);
      s = nominal_sample(); s.period_us = '1;     send_sample(s, 0);
      s = nominal_sample(); s.period_us = 16'd1;  send_sample(s, 0);
      s = nominal_sample(); s.turn_request = 16'sd328;    send_sample(s, 0);
      s = nominal_sample(); s.turn_request = 16'sd329;    send_sample(s, 0);
      s = nominal_sample(); s.turn_request = -16'sd328;   send_sample(s, 0);
      s = nominal_sample(); s.turn_request = 16'sh8000;   send_sample(s, 0);
      // translation at and just past the speed threshold
      s = nominal_sample(); s.speed_x = 16'sd41;    send_sample(s, 0);
      s = nominal_sample(); s.speed_x = 16'sd42;    send_sample(s, 0);
      s = nominal_sample(); s.speed_x = '0; s.speed_y = -16'sd42;        send_sample(s, 0);
      s = nominal_sample(); s.speed_x = -16'sd41; s.speed_y = 16'sd41;   send_sample(s, 0);
      s = nominal_sample(); s.speed_x = 16'sh8000; s.speed_y = 16'sh7fff; send_sample(s, 0);
      // heading extremes, in range and beyond, then gyro rate extremes
      s = nominal_sample(); s.heading = HEAD_W'(-PI_Q);    send_sample(s, 0);
      s = nominal_sample(); s.heading = HEAD_W'(PI_Q - 1); send_sample(s, 0);
      s = nominal_sample(); s.heading = 15'sh4000; send_sample(s, 0);
      s = nominal_sample(); s.heading = 15'sh3fff; send_sample(s, 0);
      s = nominal_sample(); s.gyro_rate = 16'sh7fff; send_sample(s, 0);
      s = nominal_sample(); s.gyro_rate = 16'sh8000; send_sample(s, 0);
      s = nominal_sample(); s.heading = 15'sd12000; s.gyro_rate = 16'sh8000; send_sample(s, 0);
      s = nominal_sample(); s.heading = '0; s.gyro_rate = '0; send_sample(s, 0);

      // random phases under changing settings and idle patterns
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         write_settings(phase_settings(ph));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_sample(random_sample(active_cfg), gap_pct[ph % 4]);
         end
      end

      drain_results();
      repeat (HH_LATENCY + 4) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
